/* design/timer_slot_dispatcher_unit_assert.svh */
// Assertion macros shared by the timer slot dispatcher checkers.
// No dependencies; included inside checker module bodies.
`ifndef TIMER_SLOT_DISPATCHER_UNIT_ASSERT_SVH
`define TIMER_SLOT_DISPATCHER_UNIT_ASSERT_SVH

// same-cycle implication
`define TSD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsd assertion failed");

// next-cycle implication
`define TSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsd assertion failed");

`endif

/* design/tsd_pkg.sv */
// Package for the timer slot dispatcher: sizes, codes and state type.
// No dependencies.
package tsd_pkg;

  localparam int SLOTS       = 8;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int MAX_RESULTS = 8;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_NUM_W  = 3;
  localparam int PADDR_W     = 3;

  localparam logic [31:0] TICK_PERIOD_RESET = 32'd1000000;

  localparam logic [1:0] KIND_CLOSED   = 2'd0;
  localparam logic [1:0] KIND_INTERVAL = 2'd1;
  localparam logic [1:0] KIND_DEFERRED = 2'd2;

  localparam logic [1:0] REQ_CREATE  = 2'd0;
  localparam logic [1:0] REQ_DESTROY = 2'd1;
  localparam logic [1:0] REQ_TICK    = 2'd2;
  localparam logic [1:0] REQ_CHECK   = 2'd3;

  localparam logic [1:0] RC_CREATED = 2'd0;
  localparam logic [1:0] RC_FULL    = 2'd1;
  localparam logic [1:0] RC_FIRED   = 2'd2;

  // word index of tick_period within paddr[2]
  localparam logic REG_TICK_PERIOD = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CREATE,
    ST_WALK,
    ST_FLUSH
  } state_t;

endpackage

/* design/timer_slot_dispatcher_unit.sv */
// Timer slot dispatcher top level: slot table, sequencer and shared slot unit.
// Depends on tsd_pkg.
//
//  port group   dir   contents
//  s_t*         in    request items (type in tuser, create/destroy args in tdata)
//  m_t*         out   result items (code in tuser, slot in tdata, tlast on last)
//  p*           cfg   APB register port, tick_period at byte 0
//
// Tick and check items pass through the accept, one setup read, one slot a cycle
// through the shared subtract/compare unit behind the registered table read
// (when the output does not stall), an end step and a flush step. Create passes
// through the accept and the create state; destroy ends in its accept. A full
// output register stalls create, the walk and the flush. rst is synchronous; it
// closes all slots and restores tick_period.
module timer_slot_dispatcher_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [39:0]                s_tdata,  // new_kind[1:0], period[33:2], slot_index[36:34]
  input  logic [1:0]                 s_tuser,  // req_type
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,  // slot_number[2:0]
  output logic [1:0]                 m_tuser,  // result_code
  output logic                       m_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tsd_pkg::*;

  state_t state, state_next;

  logic [31:0] tick_period;
  logic [1:0]  kind [SLOTS];
  logic [31:0] mem_per [SLOTS];
  logic [31:0] mem_rem [SLOTS];

  logic        req_tick;
  logic [1:0]  cr_kind;
  logic [31:0] cr_period;

  logic [CNT_W-1:0] rd_cnt;
  logic             proc_valid;
  logic [IDX_W-1:0] proc_idx;
  logic [31:0]      rd_per;
  logic [31:0]      rd_rem;

  logic                  pend_valid;
  logic [SLOT_NUM_W-1:0] pend_slot;
  logic [RES_W-1:0]      res_cnt;

  logic                  out_valid;
  logic [1:0]            out_code;
  logic [SLOT_NUM_W-1:0] out_slot;
  logic                  out_last;

  logic             accept;
  logic             out_free;
  logic             out_load;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [1:0]       cur_kind;
  logic [32:0]      diff;
  logic             ge;
  logic             lt2;
  logic             fire;
  logic             fire_emit;
  logic             wr_rem;
  logic [31:0]      new_rem;
  logic             stall;
  logic             walk_go;
  logic             rd_more;
  logic             cfg_wr;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_TICK_PERIOD);

  // lowest closed slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (kind[i] == KIND_CLOSED) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // shared slot unit: one subtract and one compare against 2*tick_period
  always_comb begin
    cur_kind = kind[proc_idx];
    diff     = {1'b0, rd_rem} - {1'b0, tick_period};
    ge       = !diff[32];
    lt2      = {1'b0, rd_rem} < {tick_period, 1'b0};
    fire     = 1'b0;
    wr_rem   = 1'b0;
    new_rem  = diff[31:0];
    if (req_tick) begin
      if (cur_kind != KIND_CLOSED && ge) begin
        wr_rem = 1'b1;
        if (cur_kind == KIND_INTERVAL && lt2) begin
          fire    = 1'b1;
          new_rem = rd_per;
        end
      end
    end else begin
      if (cur_kind == KIND_DEFERRED && !ge) begin
        fire    = 1'b1;
        wr_rem  = 1'b1;
        new_rem = rd_per;
      end
    end
    fire_emit = fire && (res_cnt < RES_W'(MAX_RESULTS));
  end

  assign stall   = proc_valid && fire_emit && pend_valid && !out_free;
  assign walk_go = (state == ST_WALK) && !stall;
  assign rd_more = rd_cnt < CNT_W'(SLOTS);

  assign out_load = (state == ST_CREATE && out_free) ||
                    (walk_go && proc_valid && fire_emit && pend_valid) ||
                    (state == ST_FLUSH && pend_valid && out_free);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (s_tuser == REQ_CREATE) state_next = ST_CREATE;
          else if (s_tuser == REQ_DESTROY)    state_next = ST_IDLE;
          else                                 state_next = ST_WALK;
        end
      end
      ST_CREATE: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_WALK: begin
        if (walk_go && !rd_more && !proc_valid) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = out_valid;
    m_tuser  = out_code;
    m_tdata  = {{(8 - SLOT_NUM_W){1'b0}}, out_slot};
    m_tlast  = out_last;
    pready   = 1'b1;
    prdata   = (paddr[2] == REG_TICK_PERIOD) ? tick_period : 32'd0;
  end

  // slot table memories
  always_ff @(posedge clk) begin
    if (state == ST_CREATE && out_free && free_found) begin
      mem_per[free_idx] <= cr_period;
      mem_rem[free_idx] <= cr_period;
    end else if (walk_go && proc_valid && wr_rem) begin
      mem_rem[proc_idx] <= new_rem;
    end
    if (walk_go && rd_more) begin
      rd_per <= mem_per[rd_cnt[IDX_W-1:0]];
      rd_rem <= mem_rem[rd_cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      tick_period <= TICK_PERIOD_RESET;
      for (int i = 0; i < SLOTS; i++) kind[i] <= KIND_CLOSED;
      out_valid   <= 1'b0;
      pend_valid  <= 1'b0;
      proc_valid  <= 1'b0;
      rd_cnt      <= '0;
      res_cnt     <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) tick_period <= pwdata;
      if (!out_load && out_valid && m_tready) out_valid <= 1'b0;

      if (accept) begin
        req_tick  <= (s_tuser == REQ_TICK);
        cr_kind   <= s_tdata[1:0];
        cr_period <= s_tdata[33:2];
        if (s_tuser == REQ_DESTROY && {29'd0, s_tdata[36:34]} < 32'(SLOTS)) begin
          kind[IDX_W'(s_tdata[36:34])] <= KIND_CLOSED;
        end
        rd_cnt     <= '0;
        proc_valid <= 1'b0;
        pend_valid <= 1'b0;
        res_cnt    <= '0;
      end

      if (state == ST_CREATE && out_free) begin
        out_valid <= 1'b1;
        out_last  <= 1'b1;
        if (free_found) begin
          kind[free_idx] <= cr_kind;
          out_code       <= RC_CREATED;
          out_slot       <= SLOT_NUM_W'(free_idx);
        end else begin
          out_code <= RC_FULL;
          out_slot <= '0;
        end
      end

      if (walk_go) begin
        proc_valid <= rd_more;
        proc_idx   <= rd_cnt[IDX_W-1:0];
        if (rd_more) rd_cnt <= rd_cnt + 1'b1;
        // hold one fired slot back so the last one can carry tlast
        if (proc_valid && fire_emit) begin
          if (pend_valid) begin
            out_valid <= 1'b1;
            out_code  <= RC_FIRED;
            out_slot  <= pend_slot;
            out_last  <= 1'b0;
          end
          pend_valid <= 1'b1;
          pend_slot  <= SLOT_NUM_W'(proc_idx);
          res_cnt    <= res_cnt + 1'b1;
        end
      end

      if (state == ST_FLUSH && pend_valid && out_free) begin
        out_valid  <= 1'b1;
        out_code   <= RC_FIRED;
        out_slot   <= pend_slot;
        out_last   <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/tsd_checker.sv */
// Port-level checker for the timer slot dispatcher, bound to the top level.
// Depends on tsd_pkg and timer_slot_dispatcher_unit_assert.svh.
module tsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [1:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);
  import tsd_pkg::*;

  logic [10:0] out_word;
  logic        rc_create;
  logic        in_acc;
  logic        walk_req;

  assign out_word  = {m_tlast, m_tuser, m_tdata};
  assign rc_create = (m_tuser == RC_CREATED) || (m_tuser == RC_FULL);
  assign in_acc    = s_tvalid && s_tready;
  assign walk_req  = (s_tuser == REQ_TICK) || (s_tuser == REQ_CHECK);

  `include "timer_slot_dispatcher_unit_assert.svh"

  // a stalled result holds
  `TSD_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(out_word))
  // a create answers with exactly one item
  `TSD_ASSERT_NOW(a_create_last, clk, rst, m_tvalid && rc_create, m_tlast)
  // destroy finishes in its accept cycle
  `TSD_ASSERT_NEXT(a_destroy_fast, clk, rst, in_acc && s_tuser == REQ_DESTROY, s_tready)
  // tick and check items are busy afterward
  `TSD_ASSERT_NEXT(a_walk_busy, clk, rst, in_acc && walk_req, !s_tready)

endmodule

bind timer_slot_dispatcher_unit tsd_checker u_tsd_checker (.*);
